// ===== rtl/ps2mc_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet cursor block.
// No dependencies; imported by the top level and by its checker.
package ps2mc_pkg;

  // Default cursor coordinate width (cursor range is 0 .. 2**COORD_BITS-1)
  localparam int DEF_COORD_BITS = 12;

  // Configuration register widths, indexes and reset values
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_INDEX_W   = 1;
  localparam int SCREEN_W_RST  = 640;
  localparam int SCREEN_H_RST  = 480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  // Request kinds carried on in_tuser
  typedef enum logic {
    OP_BYTE   = 1'b0,
    OP_REINIT = 1'b1
  } op_t;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int OUT_COORD_W = 12;
  localparam int BUTTON_W    = 3;
  localparam int DX_W        = 8;
  localparam int DY_W        = 9;
  localparam int POS_W       = 2;

  // Flags byte decoding
  localparam logic [BYTE_W-1:0] FLAG_SYNC_MASK   = 8'h08;
  localparam logic [BYTE_W-1:0] FLAG_BUTTON_MASK = 8'h07;

  // Result tdata layout, lowest bit first
  localparam int OUT_X_LO   = 0;
  localparam int OUT_Y_LO   = OUT_X_LO + OUT_COORD_W;
  localparam int OUT_BTN_LO = OUT_Y_LO + OUT_COORD_W;
  localparam int OUT_DX_LO  = OUT_BTN_LO + BUTTON_W;
  localparam int OUT_DY_LO  = OUT_DX_LO + DX_W;
  localparam int OUT_OK_BIT = OUT_DY_LO + DY_W;
  localparam int OUT_USED_W = OUT_OK_BIT + 1;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Negated Y delta can never be -128 (raw Y spans -128..127)
  localparam logic [DY_W-1:0] DY_NEVER = 9'h180;

endpackage

// ===== rtl/ps2_mouse_packet_cursor.sv =====
// An accepted request passes through the input register, then one pass of decode/clamp
// logic, into the result register; out_tready low while a result waits holds it there.
// Throughput: one byte per cycle while out_tready does not stall the result register.
// Reset (rst_n low, synchronous): screen 640x480, cursor centered, packet
// state cleared, both stages empty.
// Depends on ps2mc_pkg.
module ps2_mouse_packet_cursor
  import ps2mc_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input byte channel
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [BYTE_W-1:0]       in_tdata,   // [7:0] byte_in
  input  logic                    in_tuser,   // [0] operation
  // Result channel
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [11:0] cursor_x, [23:12] cursor_y, [26:24] button_bits,
  // [34:27] last_dx, [43:35] last_dy, [44] packet_ok, [47:45] zero
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic                    out_tlast,  // packet_done
  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int SW   = CB + 1;                       // effective screen size
  localparam int EW   = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;
  localparam int SUMW = CB + 2;                       // signed cursor + delta
  localparam logic [EW-1:0] SizeTop = {{(EW-1){1'b0}}, 1'b1} << CB;
  localparam int RstWEff = (SCREEN_W_RST > 2**CB) ? 2**CB : SCREEN_W_RST;
  localparam int RstHEff = (SCREEN_H_RST > 2**CB) ? 2**CB : SCREEN_H_RST;
  localparam logic [CB-1:0] RstCol = CB'(RstWEff / 2);
  localparam logic [CB-1:0] RstRow = CB'(RstHEff / 2);

  // Configuration registers
  logic [CFG_DATA_W-1:0] screen_w_r, screen_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= CFG_DATA_W'(SCREEN_W_RST);
      screen_h_r <= CFG_DATA_W'(SCREEN_H_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_w_r <= cfg_data;
        REG_SCREEN_HEIGHT: screen_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective screen size: 0 acts as 1, above 2**CB acts as 2**CB
  logic [EW-1:0] w_ext, h_ext;
  logic [SW-1:0] eff_w, eff_h;

  always_comb begin
    w_ext = EW'(screen_w_r);
    h_ext = EW'(screen_h_r);
    if (w_ext == '0)         w_ext = EW'(1);
    else if (w_ext > SizeTop) w_ext = SizeTop;
    if (h_ext == '0)         h_ext = EW'(1);
    else if (h_ext > SizeTop) h_ext = SizeTop;
    eff_w = w_ext[SW-1:0];
    eff_h = h_ext[SW-1:0];
  end

  // Handshake between the stages
  logic s1_valid_r;
  logic s1_op_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic out_valid_r;
  logic s2_ready, s1_fire;

  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  // Packet and cursor state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [BYTE_W-1:0]   flags_r, flags_nxt;
  logic [BYTE_W-1:0]   xbyte_r, xbyte_nxt;
  logic [CB-1:0]       col_r, col_nxt;
  logic [CB-1:0]       row_r, row_nxt;
  logic [BUTTON_W-1:0] btn_r, btn_nxt;
  logic [DX_W-1:0]     mx_r, mx_nxt;
  logic [DY_W-1:0]     my_r, my_nxt;
  logic                done, ok;

  // Deltas scaled by 1/4, rounding toward zero
  logic signed [DX_W:0]   dx_adj, dx_q;
  logic signed [DY_W-1:0] dy_neg;
  logic signed [DY_W:0]   dy_adj, dy_q;
  logic signed [SUMW-1:0] x_sum, y_sum;
  logic signed [SUMW-1:0] w_lim, h_lim;
  logic [SW-1:0]          w_m1, h_m1;

  always_comb begin
    dx_adj = $signed({xbyte_r[BYTE_W-1], xbyte_r})
             + (xbyte_r[BYTE_W-1] ? (DX_W+1)'(3) : '0);
    dx_q   = dx_adj >>> 2;
    dy_neg = -$signed({s1_byte_r[BYTE_W-1], s1_byte_r});
    dy_adj = $signed({dy_neg[DY_W-1], dy_neg})
             + (dy_neg[DY_W-1] ? (DY_W+1)'(3) : '0);
    dy_q   = dy_adj >>> 2;
    x_sum  = $signed({2'b00, col_r}) + $signed({{(SUMW-DX_W-1){dx_q[DX_W]}}, dx_q});
    y_sum  = $signed({2'b00, row_r}) + $signed({{(SUMW-DY_W-1){dy_q[DY_W]}}, dy_q});
    w_lim  = $signed({1'b0, eff_w});
    h_lim  = $signed({1'b0, eff_h});
    w_m1   = eff_w - SW'(1);
    h_m1   = eff_h - SW'(1);
  end

  // One step of the packet decoder
  always_comb begin
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    xbyte_nxt = xbyte_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    btn_nxt   = btn_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    done      = 1'b0;
    ok        = 1'b0;
    if (op_t'(s1_op_r) == OP_REINIT) begin
      pos_nxt   = '0;
      flags_nxt = '0;
      xbyte_nxt = '0;
      col_nxt   = eff_w[SW-1:1];
      row_nxt   = eff_h[SW-1:1];
      btn_nxt   = '0;
      mx_nxt    = '0;
      my_nxt    = '0;
    end else if (!pos_r[1]) begin
      if (pos_r[0]) xbyte_nxt = s1_byte_r;
      else          flags_nxt = s1_byte_r;
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      // Third byte completes the packet
      done    = 1'b1;
      pos_nxt = '0;
      if ((flags_r & FLAG_SYNC_MASK) != '0) begin
        ok      = 1'b1;
        btn_nxt = BUTTON_W'(flags_r & FLAG_BUTTON_MASK);
        mx_nxt  = xbyte_r;
        my_nxt  = dy_neg;
        if (x_sum < 0)           col_nxt = '0;
        else if (x_sum >= w_lim) col_nxt = w_m1[CB-1:0];
        else                     col_nxt = x_sum[CB-1:0];
        if (y_sum < 0)           row_nxt = '0;
        else if (y_sum >= h_lim) row_nxt = h_m1[CB-1:0];
        else                     row_nxt = y_sum[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      flags_r <= '0;
      xbyte_r <= '0;
      col_r   <= RstCol;
      row_r   <= RstRow;
      btn_r   <= '0;
      mx_r    <= '0;
      my_r    <= '0;
    end else if (s1_fire) begin
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      xbyte_r <= xbyte_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      btn_r   <= btn_nxt;
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
    end
  end

  // Result register
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= OUT_TDATA_W'({ok, my_nxt, mx_nxt, btn_nxt,
                                  OUT_COORD_W'(row_nxt), OUT_COORD_W'(col_nxt)});
      out_last_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/ps2mc_checker.sv =====
// Port-level checks for ps2_mouse_packet_cursor, bound to the top level.
// Depends on ps2mc_pkg for the result field layout.
module ps2mc_checker
  import ps2mc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // The result stage comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A good packet can only be reported on its completing byte
  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_OK_BIT] |-> out_tlast)
    else $error("packet_ok without packet_done");

  // Negated Y delta stays within -127..128
  a_dy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DY_LO +: DY_W] != DY_NEVER)
    else $error("last_dy out of range");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind ps2_mouse_packet_cursor ps2mc_checker u_ps2mc_checker (.*);
